[hdl/bfsk_pkg.sv]
// Shared types and constants for the string-key Bloom filter unit.
// Holds the controller state type, hash seed table and register map.
// No dependencies.
package bfsk_pkg;

    // Seed table size and hash lane constants
    localparam int TABLE_SIZE = 7;
    localparam logic [31:0] MULT_INIT = 32'd63689;
    localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] SEEDS [TABLE_SIZE] = '{
        32'd5, 32'd7, 32'd11, 32'd13, 32'd31, 32'd37, 32'd61
    };

    // Bit store organisation: 32-bit words, low index bits pick the bit
    localparam int WORD_BITS     = 32;
    localparam int WORD_SEL_BITS = 5;

    // Register map (word index taken from paddr[2])
    localparam logic REG_NUM_HASHES = 1'b0;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

[hdl/bloom_filter_string_keys_unit.sv]
// Bloom filter over byte-string keys: hash lanes, index reduction pipeline,
// bit store memory and its read-modify-write controller.
// Depends on bfsk_pkg.
//
// Usage
//   Key bytes enter one per beat on start/key_byte/key_last/operation; a beat
//   is taken at a clock edge with start high and busy low. Every byte is
//   hashed by up to seven lanes in the cycle it is taken, so a key body
//   streams at one byte per cycle.
//   On the last byte the block raises busy and works out k = num_hashes bit
//   indices: it issues them into a five-stage reduce-modulo pipeline, waits
//   in a drain state until all k sit in the index list, then per index
//   reads the single-port bit store and then writes back or tests, and
//   finishes. Done pulses for one cycle with found/was_query in the same
//   cycle in which busy falls. A non-last byte yields no result.
//   The result is shown for one cycle only; the receiver takes it then.
//   After reset the block sweeps the bit store to zero, one 32-bit word a
//   cycle over ceil(BIT_COUNT/32) words (32768 at the default size), with busy
//   high. num_hashes can be written over APB outside a store pass, including
//   during the sweep; the pass reads it live, so it must stay unchanged
//   from a last byte until its result.
module bloom_filter_string_keys_unit #(
    parameter int BIT_COUNT     = 1048576,
    parameter int INDEX_MODULUS = 1000000,
    parameter int MAX_HASHES    = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    // result channel
    output logic        done,
    output logic        found,
    output logic        was_query,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Derived widths and reciprocal constants
    localparam int IW    = $clog2(INDEX_MODULUS);
    localparam int BW    = $clog2(BIT_COUNT);
    localparam int AW    = BW - bfsk_pkg::WORD_SEL_BITS;
    localparam int WORDS = (BIT_COUNT + bfsk_pkg::WORD_BITS - 1) / bfsk_pkg::WORD_BITS;
    localparam int CW    = ((IW > BW) ? IW : BW) + 1;
    localparam int HCW   = $clog2(MAX_HASHES + 1);
    localparam int HIW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int S1    = 31 + IW;
    localparam logic [63:0] R1_FULL = (64'd1 << S1) / 64'(INDEX_MODULUS);
    localparam logic [31:0] R1      = R1_FULL[31:0];
    localparam int S2    = IW + BW;
    localparam int R2W   = IW + 1;
    localparam int P2W   = IW + R2W;
    localparam logic [63:0] R2_FULL = (64'd1 << S2) / 64'(BIT_COUNT);
    localparam logic [R2W-1:0] R2   = R2_FULL[R2W-1:0];

    // Controller state and counters
    bfsk_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic [HCW-1:0]   issue_cnt_reg;
    logic [HCW-1:0]   wr_cnt_reg;
    logic [HCW-1:0]   mem_cnt_reg;
    logic [4:0]       pv_reg;
    logic             op_reg;
    logic             all_set_reg;
    logic             done_reg;
    logic             found_reg;
    logic             was_query_reg;
    logic [2:0]       num_hashes_reg;
    logic [HCW-1:0]   k_val;

    // Controller outputs
    logic             accept;
    logic             issue_en;
    logic             mem_rd_en;
    logic             mem_we;
    logic             test_en;
    logic             finish;
    logic [AW-1:0]    mem_addr;
    logic [31:0]      mem_wdata;

    // Hash lanes
    logic [31:0]      acc_reg  [MAX_HASHES];
    logic [31:0]      mult_reg [MAX_HASHES];
    logic [31:0]      sext;

    // Reduction pipeline
    logic [30:0]      x_sel;
    logic [30:0]      x1_reg, x2_reg;
    logic [62:0]      p1_reg;
    logic [62:0]      q1;
    logic [30:0]      m1_reg;
    logic [30:0]      r1;
    logic [IW-1:0]    idx3_reg, idx4_reg, idx5_reg;
    logic [P2W-1:0]   p2_reg;
    logic [IW-1:0]    q2;
    logic [IW-1:0]    m2_reg;
    logic [CW-1:0]    r2;
    logic [BW-1:0]    bidx;
    logic [BW-1:0]    idx_reg [MAX_HASHES];

    // Bit store
    logic [31:0]      bits_mem [WORDS];
    logic [31:0]      mem_q_reg;
    logic [BW-1:0]    cur_idx;
    logic [bfsk_pkg::WORD_SEL_BITS-1:0] cur_bit;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bfsk_pkg::REG_NUM_HASHES) ? {29'd0, num_hashes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg <= 3'd3;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == bfsk_pkg::REG_NUM_HASHES)
        begin
            num_hashes_reg <= pwdata[2:0];
        end
    end

    // Active hash count: zero acts as one, clamp to lane count
    always_comb
    begin
        priority if (num_hashes_reg == 3'd0)
            k_val = HCW'(1);
        else if (int'(num_hashes_reg) > MAX_HASHES)
            k_val = HCW'(MAX_HASHES);
        else
            k_val = HCW'(num_hashes_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfsk_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(WORDS - 1))
                    state_next = bfsk_pkg::ST_IDLE;
            end
            bfsk_pkg::ST_IDLE:
            begin
                if (start && key_last)
                    state_next = bfsk_pkg::ST_ISSUE;
            end
            bfsk_pkg::ST_ISSUE:
            begin
                if (issue_cnt_reg == k_val - HCW'(1))
                    state_next = bfsk_pkg::ST_DRAIN;
            end
            bfsk_pkg::ST_DRAIN:
            begin
                if (wr_cnt_reg == k_val)
                    state_next = bfsk_pkg::ST_READ;
            end
            bfsk_pkg::ST_READ:
            begin
                state_next = bfsk_pkg::ST_MODIFY;
            end
            bfsk_pkg::ST_MODIFY:
            begin
                if (mem_cnt_reg == k_val - HCW'(1))
                    state_next = bfsk_pkg::ST_DONE;
                else
                    state_next = bfsk_pkg::ST_READ;
            end
            bfsk_pkg::ST_DONE:
            begin
                state_next = bfsk_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bfsk_pkg::ST_IDLE;
            end
        endcase
    end

    // Current bit store index under the read-modify-write pass
    assign cur_idx = idx_reg[mem_cnt_reg[HIW-1:0]];
    assign cur_bit = cur_idx[bfsk_pkg::WORD_SEL_BITS-1:0];

    // Controller outputs
    always_comb
    begin
        busy      = 1'b1;
        accept    = 1'b0;
        issue_en  = 1'b0;
        mem_rd_en = 1'b0;
        mem_we    = 1'b0;
        test_en   = 1'b0;
        finish    = 1'b0;
        mem_addr  = cur_idx[BW-1:bfsk_pkg::WORD_SEL_BITS];
        mem_wdata = mem_q_reg | (32'd1 << cur_bit);
        unique case (state_reg)
            bfsk_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 32'd0;
            end
            bfsk_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            bfsk_pkg::ST_ISSUE:
            begin
                issue_en = 1'b1;
            end
            bfsk_pkg::ST_DRAIN:
            begin
            end
            bfsk_pkg::ST_READ:
            begin
                mem_rd_en = 1'b1;
            end
            bfsk_pkg::ST_MODIFY:
            begin
                mem_we  = (op_reg == bfsk_pkg::OP_INSERT);
                test_en = (op_reg == bfsk_pkg::OP_QUERY);
            end
            bfsk_pkg::ST_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfsk_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            wr_cnt_reg    <= '0;
            mem_cnt_reg   <= '0;
            pv_reg        <= '0;
            op_reg        <= bfsk_pkg::OP_INSERT;
            all_set_reg   <= 1'b1;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            was_query_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            pv_reg    <= {pv_reg[3:0], issue_en};
            if (state_reg == bfsk_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (accept && key_last)
                op_reg <= operation;
            if (issue_en)
                issue_cnt_reg <= issue_cnt_reg + HCW'(1);
            if (pv_reg[4])
                wr_cnt_reg <= wr_cnt_reg + HCW'(1);
            if (state_reg == bfsk_pkg::ST_MODIFY)
                mem_cnt_reg <= mem_cnt_reg + HCW'(1);
            if (test_en && !mem_q_reg[cur_bit])
                all_set_reg <= 1'b0;
            if (finish)
            begin
                found_reg     <= (op_reg == bfsk_pkg::OP_QUERY) && all_set_reg;
                was_query_reg <= op_reg;
                issue_cnt_reg <= '0;
                wr_cnt_reg    <= '0;
                mem_cnt_reg   <= '0;
                all_set_reg   <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign was_query = was_query_reg;

    // Hash lanes: acc = acc*mult + sext(byte), mult = mult*seed
    assign sext = {{24{key_byte[7]}}, key_byte};

    for (genvar i = 0; i < MAX_HASHES; i++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[i]  <= '0;
                mult_reg[i] <= bfsk_pkg::MULT_INIT;
            end
            else if (finish)
            begin
                acc_reg[i]  <= '0;
                mult_reg[i] <= bfsk_pkg::MULT_INIT;
            end
            else if (accept)
            begin
                acc_reg[i]  <= acc_reg[i] * mult_reg[i] + sext;
                mult_reg[i] <= mult_reg[i] * bfsk_pkg::SEEDS[i];
            end
        end
    end

    // Reduction pipeline: 31-bit hash mod INDEX_MODULUS, then mod BIT_COUNT,
    // each by reciprocal multiply, back-multiply and one corrective subtract
    assign x_sel = 31'(acc_reg[issue_cnt_reg[HIW-1:0]] & bfsk_pkg::HASH_MASK);
    assign q1    = p1_reg >> S1;
    assign r1    = x2_reg - m1_reg;
    assign q2    = IW'(p2_reg >> S2);
    assign r2    = CW'(idx5_reg - m2_reg);
    assign bidx  = (r2 >= CW'(BIT_COUNT)) ? BW'(r2 - CW'(BIT_COUNT)) : BW'(r2);

    always_ff @(posedge clk)
    begin
        // stage 1: reciprocal product
        x1_reg   <= x_sel;
        p1_reg   <= 63'(x_sel) * 63'(R1);
        // stage 2: quotient estimate times modulus
        x2_reg   <= x1_reg;
        m1_reg   <= 31'(q1[30:0] * 31'(INDEX_MODULUS));
        // stage 3: remainder with one correction
        idx3_reg <= (r1 >= 31'(INDEX_MODULUS)) ? IW'(r1 - 31'(INDEX_MODULUS)) : IW'(r1);
        // stage 4: reciprocal product for the store wrap
        idx4_reg <= idx3_reg;
        p2_reg   <= P2W'(idx3_reg) * P2W'(R2);
        // stage 5: quotient estimate times store size
        idx5_reg <= idx4_reg;
        m2_reg   <= IW'(q2 * IW'(BIT_COUNT));
        // final: bit index into the index list
        if (pv_reg[4])
            idx_reg[wr_cnt_reg[HIW-1:0]] <= bidx;
    end

    // Bit store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bits_mem[mem_addr] <= mem_wdata;
        if (mem_rd_en)
            mem_q_reg <= bits_mem[mem_addr];
    end

endmodule

[hdl/bfsk_checker.sv]
// Port-level checks for the string-key Bloom filter unit, bound to the top.
// Watches the command, result and configuration ports only.
// Depends on bloom_filter_string_keys_unit.
module bfsk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        operation,
    input logic [7:0]  key_byte,
    input logic        key_last,
    input logic        done,
    input logic        found,
    input logic        was_query,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A result only ever closes a busy spell
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding busy period");

    // An insert never reports a hit
    a_insert_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_query) |-> !found)
        else $error("insert result flagged found");

    // A byte in the middle of a key gives no result and leaves the block ready
    a_mid_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !key_last) |=> !done && !busy)
        else $error("mid-key byte produced a result or stalled");

    // The last byte of a key starts the store pass
    a_last_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key_last) |=> busy)
        else $error("last byte did not start the store pass");

    // Configuration access completes without wait states
    a_apb_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("configuration access stalled");

endmodule

bind bloom_filter_string_keys_unit bfsk_checker u_bfsk_checker (.*);

[sim/tb_bloom_filter_string_keys_unit.sv]
// Self-checking bench for the string-key Bloom filter unit: key bytes in over start/busy,
// answers checked against an in-bench model of the hash lanes and bit store.
// Depends on bfsk_pkg and bloom_filter_string_keys_unit.
module tb_bloom_filter_string_keys_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BIT_COUNT     = 1048576;
    localparam int          INDEX_MODULUS = 1000000;
    localparam int          MAX_HASHES    = 7;
    localparam logic [31:0] IDX_MOD       = 32'd1000000;
    localparam logic [31:0] STORE_SIZE    = 32'd1048576;
    localparam int          SETTLE_CYCLES = 3 * MAX_HASHES + 12;
    localparam int          BEATS_PER_PHASE = 307;
    localparam int          N_DIRECTED    = 23;
    localparam int          N_SAVED       = 64;

    typedef struct packed {
        logic found;
        logic was_query;
    } answer_t;

    // one directed beat; typed rows carry their own answer
    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic       t_found;
    } key_row_t;

    localparam key_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // empty filter, then insert and find a one-byte key
        '{bfsk_pkg::OP_QUERY,  8'h61, 1'b1, 1'b1, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h61, 1'b1, 1'b1, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h61, 1'b1, 1'b1, 1'b1},
        // byte extremes: zero, all ones, sign bit alone, largest positive
        '{bfsk_pkg::OP_INSERT, 8'h00, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h80, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h7F, 1'b1, 1'b1, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h00, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'hFF, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h80, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h7F, 1'b1, 1'b1, 1'b1},
        // same bytes reordered
        '{bfsk_pkg::OP_QUERY,  8'hFF, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h80, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h00, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h7F, 1'b1, 1'b0, 1'b0},
        // operation flips within a key: the last byte decides
        '{bfsk_pkg::OP_QUERY,  8'h78, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h79, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h7A, 1'b1, 1'b1, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h78, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_INSERT, 8'h79, 1'b0, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h7A, 1'b1, 1'b1, 1'b1},
        // a lone zero byte is still a key
        '{bfsk_pkg::OP_INSERT, 8'h00, 1'b1, 1'b0, 1'b0},
        '{bfsk_pkg::OP_QUERY,  8'h00, 1'b1, 1'b1, 1'b1}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        operation = 1'b0;
    logic [7:0]  key_byte  = 8'h00;
    logic        key_last  = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'b000;
    logic [31:0] pwdata    = 32'h0;
    logic        busy;
    logic        done;
    logic        found;
    logic        was_query;
    logic [31:0] prdata;
    logic        pready;

    // filter model state
    logic [31:0] lane_acc  [bfsk_pkg::TABLE_SIZE];
    logic [31:0] lane_mult [bfsk_pkg::TABLE_SIZE];
    bit          filter_bits [BIT_COUNT];
    logic [2:0]  hash_count;

    answer_t     pending_answers [$];
    int          fail_count    = 0;
    int          beats_sent    = 0;
    int          answers_seen  = 0;
    int          queries_seen  = 0;
    int          hits_seen     = 0;
    int          idle_pct      = 38;

    logic [127:0] saved_keys [N_SAVED];
    int           saved_lens [N_SAVED];
    int           saved_n = 0;

    bloom_filter_string_keys_unit #(
        .BIT_COUNT     (BIT_COUNT),
        .INDEX_MODULUS (INDEX_MODULUS),
        .MAX_HASHES    (MAX_HASHES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .key_byte  (key_byte),
        .key_last  (key_last),
        .done      (done),
        .found     (found),
        .was_query (was_query),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_lanes();
        for (int i = 0; i < bfsk_pkg::TABLE_SIZE; i++)
        begin
            lane_acc[i]  = 32'h0;
            lane_mult[i] = bfsk_pkg::MULT_INIT;
        end
    endfunction

    // Hash one byte; on the last byte set or test the k bits
    function automatic void hash_and_probe(input logic op, input logic [7:0] b,
                                           input logic last, output logic produced,
                                           output answer_t ans);
        logic [31:0] sext;
        logic [31:0] idx;
        int          k;
        logic        all_set;
        sext = {{24{b[7]}}, b};
        for (int i = 0; i < bfsk_pkg::TABLE_SIZE; i++)
        begin
            lane_acc[i]  = lane_acc[i] * lane_mult[i] + sext;
            lane_mult[i] = lane_mult[i] * bfsk_pkg::SEEDS[i];
        end
        produced = last;
        ans      = '0;
        if (!last)
            return;
        k = int'(hash_count);
        if (k < 1)
            k = 1;
        if (k > MAX_HASHES)
            k = MAX_HASHES;
        all_set = 1'b1;
        for (int i = 0; i < k; i++)
        begin
            idx = ((lane_acc[i] & bfsk_pkg::HASH_MASK) % IDX_MOD) % STORE_SIZE;
            if (op == bfsk_pkg::OP_INSERT)
                filter_bits[idx] = 1'b1;
            else if (!filter_bits[idx])
                all_set = 1'b0;
        end
        clear_lanes();
        ans.found     = (op == bfsk_pkg::OP_QUERY) && all_set;
        ans.was_query = op;
    endfunction

    // Answer checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done === 1'b1)
        begin
            answers_seen++;
            if (was_query === 1'b1)
                queries_seen++;
            if (found === 1'b1)
                hits_seen++;
            if (pending_answers.size() == 0)
            begin
                $error("answer beat with nothing expected: found %0b, was_query %0b",
                       found, was_query);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (found !== want.found)
                begin
                    $error("found mismatch: expected %0b, got %0b", want.found, found);
                    fail_count++;
                end
                if (was_query !== want.was_query)
                begin
                    $error("was_query mismatch: expected %0b, got %0b",
                           want.was_query, was_query);
                    fail_count++;
                end
            end
        end
    end

    // Present one key byte and wait for it to be taken
    task automatic send_beat(input logic op, input logic [7:0] b, input logic last,
                             input logic typed, input logic t_found);
        int      gap;
        logic    produced;
        answer_t ans;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        key_byte  <= b;
        key_last  <= last;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        beats_sent++;
        hash_and_probe(op, b, last, produced, ans);
        if (produced)
        begin
            if (typed)
            begin
                ans.found     = t_found;
                ans.was_query = op;
            end
            pending_answers.push_back(ans);
        end
    endtask

    // Whole key; with flip set every byte but the last carries the other operation
    task automatic send_key(input logic op_last, input logic [127:0] kbuf, input int len,
                            input logic flip);
        logic op_j;
        for (int j = 0; j < len; j++)
        begin
            op_j = (flip && j != len - 1) ? ~op_last : op_last;
            send_beat(op_j, kbuf[8*j +: 8], j == len - 1, 1'b0, 1'b0);
        end
    endtask

    // Hold the sender until every answer is back, then let the block settle
    task automatic hold_until_drained(input int settle);
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_hash_count(input logic [2:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bfsk_pkg::REG_NUM_HASHES, 2'b00};
        pwdata  <= {29'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hash_count = val;
        @(posedge clk);
    endtask

    task automatic check_hash_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {bfsk_pkg::REG_NUM_HASHES, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== {29'h0, hash_count})
        begin
            $error("num_hashes mismatch: expected %0d, got %0d", hash_count, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [127:0] random_key(input int len);
        logic [127:0] kbuf;
        kbuf = '0;
        for (int j = 0; j < len; j++)
            kbuf[8*j +: 8] = ($urandom_range(99) < 30) ? 8'($urandom_range(97, 122))
                                                        : 8'($urandom);
        return kbuf;
    endfunction

    // Main sequence
    initial
    begin
        logic [2:0]   phase_count;
        logic [127:0] kbuf;
        int           len;
        int           pick;
        int           phase_base;
        int           drain_wait;
        clear_lanes();
        hash_count = 3'd3;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed keys at the reset hash count
        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].b, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].t_found);

        // Random phases: hash count and sender idling change between them
        for (int ph = 0; ph < 4; ph++)
        begin
            hold_until_drained(SETTLE_CYCLES);
            case (ph)
                0: phase_count = 3'd7;
                1: phase_count = 3'd0;
                2: phase_count = 3'd1;
                default: phase_count = 3'($urandom_range(2, 6));
            endcase
            write_hash_count(phase_count);
            check_hash_count();
            case (ph)
                0: idle_pct = 38;
                1: idle_pct = 61;
                default: idle_pct = 0;
            endcase
            phase_base = beats_sent;
            while (beats_sent - phase_base < BEATS_PER_PHASE)
            begin
                if ($urandom_range(99) < 2)
                    hold_until_drained(0);
                len  = ($urandom_range(99) < 70) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 16);
                pick = $urandom_range(99);
                if (pick < 40 || (pick < 70 && saved_n == 0))
                begin
                    // fresh insert, kept for later lookups
                    kbuf = random_key(len);
                    saved_keys[saved_n % N_SAVED] = kbuf;
                    saved_lens[saved_n % N_SAVED] = len;
                    saved_n++;
                    send_key(bfsk_pkg::OP_INSERT, kbuf, len, 1'b0);
                end
                else if (pick < 70)
                begin
                    // lookup of a key inserted earlier
                    pick = $urandom_range((saved_n < N_SAVED ? saved_n : N_SAVED) - 1);
                    send_key(bfsk_pkg::OP_QUERY, saved_keys[pick], saved_lens[pick], 1'b0);
                end
                else if (pick < 90)
                begin
                    send_key(bfsk_pkg::OP_QUERY, random_key(len), len, 1'b0);
                end
                else
                begin
                    // mixed operations within a key
                    send_key(1'($urandom), random_key(len), len, 1'b1);
                end
            end
        end

        // Drain
        start <= 1'b0;
        @(posedge clk);
        drain_wait = 0;
        while (pending_answers.size() != 0 && drain_wait < 5000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d answers never arrived", pending_answers.size());
            fail_count += pending_answers.size();
        end

        $display("Run covered %0d key bytes and %0d answers (%0d lookups, %0d hits),",
                 beats_sent, answers_seen, queries_seen, hits_seen);
        $display("with hash counts 3, 7, 0, 1 and %0d under three sender idle profiles.",
                 phase_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
